// ===== rtl/core/hex_dump_crc16_framer_defines.svh =====
// Assertion macros shared by the hex dump framer RTL.
`ifndef HEX_DUMP_CRC16_FRAMER_DEFINES_SVH
`define HEX_DUMP_CRC16_FRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clock and masked during reset.
`define HDCF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and masked during reset.
`define HDCF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/hdcf_pkg.sv =====
// Shared types, constants and helper functions of the hex dump framer.
package hdcf_pkg;

   // Default configuration
   localparam int BYTES_PER_LINE_DEF = 16;
   localparam int QUEUE_DEPTH_DEF    = 2;

   // CRC-16, reflected form
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // ASCII codes
   localparam logic [7:0] CH_M  = 8'h4D;
   localparam logic [7:0] CH_P  = 8'h50;
   localparam logic [7:0] CH_0  = 8'h30;
   localparam logic [7:0] CH_A  = 8'h61;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // One classified byte, handed from front to back
   typedef struct packed {
      logic        header;   // emit "MP" first
      logic        brk;      // emit CR LF before the digits
      logic        last;     // emit the CRC trailer after the digits
      logic [7:0]  data;
      logic [15:0] fin_crc;  // inverted CRC, used only when last is set
   } entry_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   // Character slots of the back-end sequencer
   typedef enum logic [3:0] {
      SL_M,
      SL_P,
      SL_CR_LINE,
      SL_LF_LINE,
      SL_HI,
      SL_LO,
      SL_CR_TAIL,
      SL_LF_TAIL,
      SL_CRC3,
      SL_CRC2,
      SL_CRC1,
      SL_CRC0,
      SL_CR_END,
      SL_LF_END
   } slot_type;

   // Lower-case hex digit of a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'b0000, nib};
      if (nib < 4'd10) begin
         hex_char = CH_0 + wide;
      end else begin
         hex_char = CH_A + wide - 8'd10;
      end
   endfunction

   // Fold one byte into the CRC, LSB first
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] v);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if ((c[0] ^ v[i]) == 1'b1) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_fold = c;
   endfunction

endpackage

// ===== rtl/core/hdcf_if.sv =====
// Valid/ready channel interfaces for log bytes and ASCII characters.
interface hdcf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hdcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       end_of_dump;

   modport source (output valid, output out_char, output end_of_dump, input ready);
   modport sink   (input valid, input out_char, input end_of_dump, output ready);
endinterface

// ===== rtl/core/hdcf_front.sv =====
// Front end: accepts log bytes, tracks line position and CRC, classifies each byte.
module hdcf_front #(
   parameter int BYTES_PER_LINE = hdcf_pkg::BYTES_PER_LINE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   hdcf_req_if.sink              req_chan,
   input  logic                  q_full,
   output logic                  push,
   output hdcf_pkg::entry_type   push_entry
);

   localparam int POS_W = $clog2(BYTES_PER_LINE);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(BYTES_PER_LINE - 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic             hdr_ff, hdr_in;
   logic [15:0]      crc_next;

   // Accept whenever the queue has room
   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   // Classify the incoming transaction
   always_comb begin
      crc_next            = hdcf_pkg::crc_fold(crc_ff, req_chan.data_byte);
      push_entry.header   = !hdr_ff;
      push_entry.brk      = (pos_ff == '0);
      push_entry.last     = req_chan.last_byte;
      push_entry.data     = req_chan.data_byte;
      push_entry.fin_crc  = ~crc_next;
   end

   // Dump state update; the last byte returns it to the start values
   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      hdr_in = hdr_ff;
      if (push) begin
         if (req_chan.last_byte) begin
            pos_in = '0;
            crc_in = hdcf_pkg::CRC_INIT;
            hdr_in = 1'b0;
         end else begin
            pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
            crc_in = crc_next;
            hdr_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= hdcf_pkg::CRC_INIT;
         hdr_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         hdr_ff <= hdr_in;
      end
   end

endmodule

// ===== rtl/core/hdcf_queue.sv =====
// Short FIFO of classified bytes between front and back end.
`include "hex_dump_crc16_framer_defines.svh"

module hdcf_queue #(
   parameter int DEPTH = hdcf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hdcf_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output hdcf_pkg::head_type  head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   hdcf_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full        = (count_ff == CNT_FULL);
   assign head.valid  = (count_ff != '0);
   assign head.entry  = entries_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `HDCF_ASSERT_IMP(a_no_push_full, push, !full, "queue written while full")
   `HDCF_ASSERT_IMP(a_no_pop_empty, pop, head.valid, "queue read while empty")
   `HDCF_ASSERT_IMP(a_count_range, 1'b1, count_ff <= CNT_FULL, "queue count out of range")

endmodule

// ===== rtl/core/hdcf_back.sv =====
// Back end: sequences the ASCII characters of each byte into the output register.
`include "hex_dump_crc16_framer_defines.svh"

module hdcf_back (
   input  logic               clock,
   input  logic               reset,
   input  hdcf_pkg::head_type head,
   output logic               pop,
   hdcf_rsp_if.source         rsp_chan
);

   hdcf_pkg::slot_type slot_ff, slot_in;
   hdcf_pkg::slot_type cur_slot, next_slot, first_slot;
   logic               busy_ff, busy_in;
   logic               valid_ff, valid_in;
   logic [7:0]         char_ff, char_in;
   logic               eod_ff, eod_in;
   logic               load, emit, done, eod_next;
   logic [7:0]         char_next;

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_char    = char_ff;
   assign rsp_chan.end_of_dump = eod_ff;

   // Output register can take a character when empty or being drained
   assign load = !valid_ff || rsp_chan.ready;
   assign emit = load && head.valid;
   assign pop  = emit && done;

   // Slot decode: character, successor, and end of this byte
   always_comb begin
      first_slot = head.entry.header ? hdcf_pkg::SL_M :
                   head.entry.brk    ? hdcf_pkg::SL_CR_LINE : hdcf_pkg::SL_HI;
      cur_slot   = busy_ff ? slot_ff : first_slot;
      next_slot  = cur_slot;
      char_next  = hdcf_pkg::CH_LF;
      done       = 1'b0;
      eod_next   = 1'b0;
      unique case (cur_slot)
         hdcf_pkg::SL_M: begin
            char_next = hdcf_pkg::CH_M;
            next_slot = hdcf_pkg::SL_P;
         end
         hdcf_pkg::SL_P: begin
            char_next = hdcf_pkg::CH_P;
            next_slot = head.entry.brk ? hdcf_pkg::SL_CR_LINE : hdcf_pkg::SL_HI;
         end
         hdcf_pkg::SL_CR_LINE: begin
            char_next = hdcf_pkg::CH_CR;
            next_slot = hdcf_pkg::SL_LF_LINE;
         end
         hdcf_pkg::SL_LF_LINE: begin
            char_next = hdcf_pkg::CH_LF;
            next_slot = hdcf_pkg::SL_HI;
         end
         hdcf_pkg::SL_HI: begin
            char_next = hdcf_pkg::hex_char(head.entry.data[7:4]);
            next_slot = hdcf_pkg::SL_LO;
         end
         hdcf_pkg::SL_LO: begin
            char_next = hdcf_pkg::hex_char(head.entry.data[3:0]);
            next_slot = hdcf_pkg::SL_CR_TAIL;
            done      = !head.entry.last;
         end
         hdcf_pkg::SL_CR_TAIL: begin
            char_next = hdcf_pkg::CH_CR;
            next_slot = hdcf_pkg::SL_LF_TAIL;
         end
         hdcf_pkg::SL_LF_TAIL: begin
            char_next = hdcf_pkg::CH_LF;
            next_slot = hdcf_pkg::SL_CRC3;
         end
         hdcf_pkg::SL_CRC3: begin
            char_next = hdcf_pkg::hex_char(head.entry.fin_crc[15:12]);
            next_slot = hdcf_pkg::SL_CRC2;
         end
         hdcf_pkg::SL_CRC2: begin
            char_next = hdcf_pkg::hex_char(head.entry.fin_crc[11:8]);
            next_slot = hdcf_pkg::SL_CRC1;
         end
         hdcf_pkg::SL_CRC1: begin
            char_next = hdcf_pkg::hex_char(head.entry.fin_crc[7:4]);
            next_slot = hdcf_pkg::SL_CRC0;
         end
         hdcf_pkg::SL_CRC0: begin
            char_next = hdcf_pkg::hex_char(head.entry.fin_crc[3:0]);
            next_slot = hdcf_pkg::SL_CR_END;
         end
         hdcf_pkg::SL_CR_END: begin
            char_next = hdcf_pkg::CH_CR;
            next_slot = hdcf_pkg::SL_LF_END;
         end
         hdcf_pkg::SL_LF_END: begin
            char_next = hdcf_pkg::CH_LF;
            done      = 1'b1;
            eod_next  = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   // Sequencer and output register next values
   always_comb begin
      slot_in  = slot_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      eod_in   = eod_ff;
      if (emit) begin
         slot_in  = next_slot;
         busy_in  = !done;
         valid_in = 1'b1;
         char_in  = char_next;
         eod_in   = eod_next;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= hdcf_pkg::SL_M;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      eod_ff  <= eod_in;
   end

   `HDCF_ASSERT_IMP(a_busy_has_item, busy_ff, head.valid, "byte in progress left the queue")
   `HDCF_ASSERT_IMP(a_last_ends_dump, pop && head.entry.last, eod_in, "last byte, no end flag")
   `HDCF_ASSERT_NXT(a_eod_is_lf, emit && eod_next, char_ff == hdcf_pkg::CH_LF, "end flag off LF")

endmodule

// ===== rtl/core/hex_dump_crc16_framer.sv =====
// Top level of the hex dump framer with CRC-16 trailer.
// Takes log bytes (with a last-byte mark) and gives one ASCII character per transaction:
// "MP" before the first byte of a dump, CR LF before every line of BYTES_PER_LINE bytes,
// two lower-case hex digits per byte, and after the last byte CR LF, the inverted
// CRC-16 (reflected 0x8408, start 0xFFFF) as four hex digits, and CR LF with
// end_of_dump set on that final LF; the next byte then starts a new dump. The character
// output register issues one character per cycle while the receiver is ready; a byte
// makes 2 characters in a line, 4 at a line start, 6 with the header; the trailer adds 8.
// The front end accepts a byte per cycle until its QUEUE_DEPTH-entry queue to the
// character sequencer fills; the output register lets it keep accepting while one waits.
module hex_dump_crc16_framer #(
   parameter int BYTES_PER_LINE = hdcf_pkg::BYTES_PER_LINE_DEF,
   parameter int QUEUE_DEPTH    = hdcf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hdcf_req_if.sink    req_chan,
   hdcf_rsp_if.source  rsp_chan
);

   logic                q_full;
   logic                push;
   logic                pop;
   hdcf_pkg::entry_type push_entry;
   hdcf_pkg::head_type  head;

   // Byte classification, line position and CRC
   hdcf_front #(
      .BYTES_PER_LINE (BYTES_PER_LINE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue
   hdcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head       (head)
   );

   // Character sequencer and output register
   hdcf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== verif/hex_dump_crc16_framer_tb.sv =====
// Self-checking testbench for the hex dump framer: byte stimulus, character checking.

// Predicts the character stream of the framer and checks the characters that come out.
class dump_scoreboard;
   typedef struct packed {
      logic [7:0] ch;
      logic       eod;
   } char_entry_type;

   int unsigned    line_bytes;
   int unsigned    line_pos;
   logic [15:0]    crc;
   bit             header_sent;
   char_entry_type expected_chars[$];
   int             errors;

   function new(int unsigned bytes_per_line);
      line_bytes = bytes_per_line;
      errors     = 0;
      start_dump();
   endfunction

   // State of a fresh dump, also entered after each trailer
   function void start_dump();
      line_pos    = 0;
      crc         = hdcf_pkg::CRC_INIT;
      header_sent = 1'b0;
   endfunction

   function void expect_char(logic [7:0] ch, logic eod);
      char_entry_type e;
      e.ch  = ch;
      e.eod = eod;
      expected_chars.push_back(e);
   endfunction

   function logic [7:0] ascii_hex(logic [3:0] nib);
      if (nib < 4'd10) return hdcf_pkg::CH_0 + {4'd0, nib};
      return hdcf_pkg::CH_A + {4'd0, nib} - 8'd10;
   endfunction

   function void expect_hex_byte(logic [7:0] v);
      expect_char(ascii_hex(v[7:4]), 1'b0);
      expect_char(ascii_hex(v[3:0]), 1'b0);
   endfunction

   // Reflected CRC-16 update, data LSB first
   function logic [15:0] crc_after(logic [15:0] c, logic [7:0] v);
      logic [15:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
         if ((r[0] ^ v[i]) == 1'b1) r = (r >> 1) ^ hdcf_pkg::CRC_POLY;
         else r = r >> 1;
      end
      return r;
   endfunction

   // Accepted byte: queue every character it causes
   function void note_byte(logic [7:0] v, logic last);
      logic [15:0] fin;
      if (!header_sent) begin
         expect_char(hdcf_pkg::CH_M, 1'b0);
         expect_char(hdcf_pkg::CH_P, 1'b0);
         header_sent = 1'b1;
      end
      if (line_pos == 0) begin
         expect_char(hdcf_pkg::CH_CR, 1'b0);
         expect_char(hdcf_pkg::CH_LF, 1'b0);
      end
      expect_hex_byte(v);
      crc      = crc_after(crc, v);
      line_pos = (line_pos + 1 >= line_bytes) ? 0 : line_pos + 1;
      if (last) begin
         fin = ~crc;
         expect_char(hdcf_pkg::CH_CR, 1'b0);
         expect_char(hdcf_pkg::CH_LF, 1'b0);
         expect_hex_byte(fin[15:8]);
         expect_hex_byte(fin[7:0]);
         expect_char(hdcf_pkg::CH_CR, 1'b0);
         expect_char(hdcf_pkg::CH_LF, 1'b1);
         start_dump();
      end
   endfunction

   task report_mismatch(string msg);
      // only the first hundred mismatches are printed, all are counted
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
   endtask

   // Accepted character: compare against the oldest expectation
   task check_char(logic [7:0] ch, logic eod);
      char_entry_type e;
      if (expected_chars.size() == 0) begin
         report_mismatch($sformatf("unexpected character 8'h%02h end_of_dump=%0b", ch, eod));
         return;
      end
      e = expected_chars.pop_front();
      if (ch !== e.ch)
         report_mismatch($sformatf("out_char 8'h%02h, expected 8'h%02h", ch, e.ch));
      if (eod !== e.eod)
         report_mismatch($sformatf("end_of_dump %0b, expected %0b (char 8'h%02h)",
                                   eod, e.eod, e.ch));
   endtask

   function int pending();
      return expected_chars.size();
   endfunction
endclass

module hex_dump_crc16_framer_tb;
   localparam int LINE_BYTES  = hdcf_pkg::BYTES_PER_LINE_DEF;
   localparam int TOTAL_ITEMS = 205;
   localparam int TAIL_CYCLES = 64;
   localparam int CYCLE_LIMIT = 800000;

   logic clock;
   logic reset;
   int   cycle_count;
   bit   steady;       // no idling on either side while set
   int   items_sent;

   hdcf_req_if req_chan ();
   hdcf_rsp_if rsp_chan ();

   dump_scoreboard sb = new(LINE_BYTES);

   hex_dump_crc16_framer #(
      .BYTES_PER_LINE(LINE_BYTES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Character side: check accepted transactions, stall in random bursts
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_char(rsp_chan.out_char, rsp_chan.end_of_dump);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 99) < 20) hold = idle_gap();
         end
      end
   end

   // One byte transaction, with a random gap ahead of it
   task automatic send_byte(input logic [7:0] v, input logic last);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= v;
      req_chan.last_byte <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_byte(v, last);
      items_sent++;
   endtask

   // Hold the byte side until the character side has caught up
   task automatic drain_wait();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Dump of random bytes; optionally pause for a full drain halfway through
   task automatic send_dump(input int len, input bit drain_mid);
      logic [7:0] v;
      int         r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 19);
         if (r == 0) v = 8'h00;
         else if (r == 1) v = 8'hFF;
         else v = 8'($urandom_range(0, 255));
         if (drain_mid && i == len / 2) drain_wait();
         send_byte(v, i == len - 1);
      end
   endtask

   // Directed part: single-byte dumps at the extremes, a dump that crosses a line
   // boundary and covers every hex digit, and a short text dump
   task automatic run_directed();
      logic [7:0] pattern [17];
      pattern = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hab, 8'hcd, 8'hef, 8'h9a,
                  8'h0f, 8'hf0, 8'h10, 8'h80, 8'h7f, 8'h55, 8'haa, 8'hfe};
      steady = 1'b1;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      steady = 1'b0;
      for (int i = 0; i < 17; i++) send_byte(pattern[i], i == 16);
      drain_wait();
      send_byte(8'h31, 1'b0);
      send_byte(8'h32, 1'b0);
      send_byte(8'h33, 1'b1);
   endtask

   initial begin
      int dump_idx;
      int pressure_dump;
      int r;
      int len;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= 8'h00;
      req_chan.last_byte <= 1'b0;
      steady     = 1'b0;
      items_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // Random dumps, mostly short, some spanning several lines
      dump_idx      = 0;
      pressure_dump = $urandom_range(2, 6);
      while (items_sent < TOTAL_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 8) len = LINE_BYTES * $urandom_range(1, 2);
         else if (r < 30) len = $urandom_range(1, 4);
         else if (r < 60) len = $urandom_range(5, 20);
         else if (r < 85) len = $urandom_range(21, 40);
         else len = $urandom_range(41, 70);
         steady = ($urandom_range(0, 5) == 0);
         send_dump(len, dump_idx == pressure_dump);
         dump_idx++;
      end
      steady = 1'b0;
      req_chan.valid <= 1'b0;

      // Drain, then watch for stray characters
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
